### rtl/iopit_pkg.sv
// ----------------------------------------------------------------------------
// iopit_pkg
// Shared types, codes and helpers for the I/O port and interval timer.
// ----------------------------------------------------------------------------
package iopit_pkg;

    // Operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register offsets
    localparam logic [3:0] OFS_PA_DATA   = 4'd0;
    localparam logic [3:0] OFS_PA_DIR    = 4'd1;
    localparam logic [3:0] OFS_PB_DATA   = 4'd2;
    localparam logic [3:0] OFS_PB_DIR    = 4'd3;
    localparam logic [3:0] OFS_COUNT     = 4'd6;
    localparam logic [3:0] OFS_STATUS    = 4'd7;
    localparam logic [3:0] OFS_COUNT_ALT = 4'd14;

    // Prescale select codes
    localparam logic [2:0] PS_STOPPED = 3'd0;
    localparam logic [2:0] PS_DIV1    = 3'd1;
    localparam logic [2:0] PS_DIV8    = 3'd2;
    localparam logic [2:0] PS_DIV64   = 3'd3;
    localparam logic [2:0] PS_DIV1024 = 3'd4;

    localparam int         ACC_W          = 11;
    localparam logic [7:0] RESTART_COUNT  = 8'd255;
    localparam logic [7:0] EXPIRED_STATUS = 8'h80;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] reg_offset;
        logic [7:0] write_data;
        logic [7:0] tick_cycles;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_expired;
    } out_item_t;

    // Work request handed from the input stage to the state holders
    typedef struct packed {
        logic     fire;
        in_item_t item;
    } req_t;

    function automatic logic [3:0] prescale_shift(input logic [2:0] sel);
        logic [3:0] sh;
        case (sel)
            PS_DIV1:    sh = 4'd0;
            PS_DIV8:    sh = 4'd3;
            PS_DIV64:   sh = 4'd6;
            PS_DIV1024: sh = 4'd10;
            default:    sh = 4'd0;
        endcase
        return sh;
    endfunction

endpackage

### rtl/iopit_ports.sv
// ----------------------------------------------------------------------------
// iopit_ports
// Port A and port B data and direction registers with read-back.
// ----------------------------------------------------------------------------
module iopit_ports
    import iopit_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       req,
    output logic [7:0] rd_data
);

    logic [7:0] pa_data_reg, pa_dir_reg, pb_data_reg, pb_dir_reg;
    logic       wr_en, rd_en;

    assign wr_en = req.fire && (req.item.operation == OP_WRITE)
                   && (req.item.reg_offset[3:2] == 2'b00);
    assign rd_en = (req.item.operation == OP_READ)
                   && (req.item.reg_offset[3:2] == 2'b00);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_data_reg <= '0;
            pa_dir_reg  <= '0;
            pb_data_reg <= '0;
            pb_dir_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (req.item.reg_offset)
                OFS_PA_DATA: pa_data_reg <= req.item.write_data;
                OFS_PA_DIR:  pa_dir_reg  <= req.item.write_data;
                OFS_PB_DATA: pb_data_reg <= req.item.write_data;
                OFS_PB_DIR:  pb_dir_reg  <= req.item.write_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        rd_data = '0;
        if (rd_en)
        begin
            unique case (req.item.reg_offset)
                OFS_PA_DATA: rd_data = pa_data_reg;
                OFS_PA_DIR:  rd_data = pa_dir_reg;
                OFS_PB_DATA: rd_data = pb_data_reg;
                OFS_PB_DIR:  rd_data = pb_dir_reg;
                default:     rd_data = '0;
            endcase
        end
    end

endmodule

### rtl/iopit_timer.sv
// ----------------------------------------------------------------------------
// iopit_timer
// Interval timer: prescaled count-down, expiry flag, count and status reads.
// ----------------------------------------------------------------------------
module iopit_timer
    import iopit_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       req,
    output logic [7:0] rd_data,
    output logic       expired_next
);

    logic [2:0]       sel_reg, sel_next;
    logic [7:0]       count_reg, count_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             exp_reg, exp_next;

    logic [ACC_W:0]   sum_wide;
    logic [ACC_W-1:0] sum, periods, rem_mask;
    logic [3:0]       shift;
    logic             running;

    assign sum_wide = {1'b0, acc_reg} + {{(ACC_W - 7){1'b0}}, req.item.tick_cycles};
    assign sum      = sum_wide[ACC_W-1:0];
    assign shift    = prescale_shift(sel_reg);
    assign periods  = sum >> shift;
    assign rem_mask = (ACC_W'(1) << shift) - ACC_W'(1);
    assign running  = (sel_reg >= PS_DIV1) && (sel_reg <= PS_DIV1024) && !exp_reg;

    always_comb
    begin
        sel_next   = sel_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        exp_next   = exp_reg;
        rd_data    = '0;
        case (req.item.operation)
            OP_TICK:
            begin
                if (running)
                begin
                    acc_next = sum & rem_mask;
                    // only whole periods lower the count
                    if (periods != '0)
                    begin
                        if (periods >= {3'b000, count_reg})
                        begin
                            count_next = '0;
                            exp_next   = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg - periods[7:0];
                        end
                    end
                end
            end
            OP_READ:
            begin
                if (req.item.reg_offset == OFS_COUNT || req.item.reg_offset == OFS_COUNT_ALT)
                begin
                    if (exp_reg)
                    begin
                        // restart from full count, same prescale
                        acc_next   = '0;
                        exp_next   = 1'b0;
                        count_next = RESTART_COUNT;
                    end
                    else
                    begin
                        rd_data = count_reg;
                    end
                end
                else if (req.item.reg_offset == OFS_STATUS)
                begin
                    rd_data = exp_reg ? EXPIRED_STATUS : 8'h00;
                end
            end
            OP_WRITE:
            begin
                if (req.item.reg_offset[3:2] == 2'b01)
                begin
                    sel_next   = {1'b0, req.item.reg_offset[1:0]} + PS_DIV1;
                    acc_next   = '0;
                    count_next = req.item.write_data;
                    exp_next   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign expired_next = exp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= PS_STOPPED;
            count_reg <= '0;
            acc_reg   <= '0;
            exp_reg   <= 1'b0;
        end
        else if (req.fire)
        begin
            sel_reg   <= sel_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            exp_reg   <= exp_next;
        end
    end

endmodule

### rtl/io_port_and_interval_timer.sv
// ----------------------------------------------------------------------------
// io_port_and_interval_timer
// Bus-attached I/O port registers and a prescaled interval timer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one transaction for each
//   bus access or timer tick: a timer advance, a register read or a
//   register write. Output channel (out_valid/out_ready/out_data) returns
//   exactly one result transaction per input, in order: the read byte (0 for
//   ticks, writes and undecoded offsets) and the expired flag after the item.
//   An accepted item passes the input register, then the result register.
//   Throughput: one transaction per cycle while out_ready stays high; all
//   state is updated by a single pass of short logic between the two registers.
//   Stall: while out_valid is held by a low out_ready, one more transaction
//   can sit in the input register; in_ready drops only when both are full.
//   Reset (rst_n low, asynchronous): both stages empty, ports cleared, timer
//   stopped with count 0 and the expired flag clear.
// ----------------------------------------------------------------------------
module io_port_and_interval_timer
    import iopit_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic       advance;
    req_t       req;
    logic [7:0] port_rd, timer_rd;
    logic       expired_next;

    // Advance the input stage when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign req.fire = advance;
    assign req.item = in_item_reg;

    iopit_ports u_ports (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (port_rd)
    );

    iopit_timer u_timer (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rd_data      (timer_rd),
        .expired_next (expired_next)
    );

    // Input register: hold the accepted transaction until it advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
    end

    // Result register: load on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // port and timer read data are zero outside their own offsets
            out_item_reg.read_data     <= port_rd | timer_rd;
            out_item_reg.timer_expired <= expired_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

### rtl/iopit_checker.sv
// ----------------------------------------------------------------------------
// iopit_checker
// Port-level checks for the I/O port and interval timer, bound to the top.
// ----------------------------------------------------------------------------
module iopit_checker
    import iopit_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

    // With no result pending the input side always has room
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input stalled with empty output");

    // Every accepted transaction leads to a valid result after the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
    else $error("result missing after accepted transaction");

    // Nothing comes out right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind io_port_and_interval_timer iopit_checker u_iopit_checker (.*);

### sim/io_port_and_interval_timer_test.sv
// ----------------------------------------------------------------------------
// io_port_and_interval_timer_test
// Drives bus reads, writes and cycle ticks into the port and timer block and
// checks every result, in order, against a fixed table value or a shadow of
// the port registers and the prescaled count. A directed table opens the
// run, random traffic with idle and stall bursts, then a full-rate tail.
// ----------------------------------------------------------------------------
module io_port_and_interval_timer_test;
    import iopit_pkg::*;

    // Codes the package does not name
    localparam logic [1:0] OP_IGNORED        = 2'd3;
    localparam logic [3:0] OFS_START_DIV1    = 4'd4;
    localparam logic [3:0] OFS_START_DIV8    = 4'd5;
    localparam logic [3:0] OFS_START_DIV64   = 4'd6;
    localparam logic [3:0] OFS_START_DIV1024 = 4'd7;
    localparam logic [3:0] OFS_UNMAPPED_LO   = 4'd8;
    localparam logic [3:0] OFS_WINDOW_TOP    = 4'd15;

    // Run shape
    localparam int RANDOM_ITEMS     = 400;
    localparam int QUIET_TAIL       = 60;
    localparam int DRAIN_PAUSE_AT   = 250;
    localparam int LONG_HOLD_AT     = 120;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int SETTLE_CYCLES    = 10;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int MAX_REPORTS      = 10;

    typedef struct {
        in_item_t  item;
        bit        fixed;
        out_item_t result;
    } stim_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // Shadow of the block's state, advanced once per accepted transaction
    logic [7:0]  pa_data_shadow   = '0;
    logic [7:0]  pa_dir_shadow    = '0;
    logic [7:0]  pb_data_shadow   = '0;
    logic [7:0]  pb_dir_shadow    = '0;
    logic [2:0]  prescale_shadow  = PS_STOPPED;
    logic [7:0]  reload_shadow    = '0;
    logic [7:0]  count_shadow     = '0;
    logic [10:0] acc_shadow       = '0;
    logic        expired_shadow   = 1'b0;

    out_item_t expected_results[$];
    stim_row_t stim_rows[$];

    bit idle_enabled        = 1'b1;
    int items_sent          = 0;
    int failures            = 0;
    int expirations         = 0;
    int backpressure_cycles = 0;
    int quiet_cycles        = 0;
    int op_count[4]         = '{0, 0, 0, 0};

    io_port_and_interval_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Hold reset low at the start, then release it for good
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Predictor: apply one transaction to the shadow state and return the
    // result the block must produce for it.
    // ------------------------------------------------------------------------
    function automatic out_item_t predict_port_timer(input in_item_t it);
        out_item_t   res;
        logic [3:0]  sh;
        logic [10:0] period;
        logic [10:0] whole;
        logic        was_expired;
        res = '0;
        sh = '0;
        was_expired = expired_shadow;
        case (it.operation)
            OP_TICK:
            begin
                // Advance only a running timer that has not yet expired
                if (prescale_shadow != PS_STOPPED && prescale_shadow <= PS_DIV1024
                    && !expired_shadow)
                begin
                    case (prescale_shadow)
                        PS_DIV8:    sh = 4'd3;
                        PS_DIV64:   sh = 4'd6;
                        PS_DIV1024: sh = 4'd10;
                        default:    sh = 4'd0;
                    endcase
                    period = 11'd1 << sh;
                    acc_shadow = acc_shadow + {3'b000, it.tick_cycles};
                    if (acc_shadow >= period)
                    begin
                        whole = acc_shadow >> sh;
                        acc_shadow = acc_shadow & (period - 11'd1);
                        // Reaching or passing zero pins the count and flags expiry
                        if (whole >= {3'b000, count_shadow})
                        begin
                            count_shadow = '0;
                            expired_shadow = 1'b1;
                        end
                        else
                        begin
                            count_shadow = count_shadow - whole[7:0];
                        end
                    end
                end
            end
            OP_READ:
            begin
                case (it.reg_offset)
                    OFS_PA_DATA: res.read_data = pa_data_shadow;
                    OFS_PA_DIR:  res.read_data = pa_dir_shadow;
                    OFS_PB_DATA: res.read_data = pb_data_shadow;
                    OFS_PB_DIR:  res.read_data = pb_dir_shadow;
                    OFS_COUNT, OFS_COUNT_ALT:
                    begin
                        // A count read after expiry returns zero and restarts
                        if (expired_shadow)
                        begin
                            acc_shadow = '0;
                            expired_shadow = 1'b0;
                            count_shadow = RESTART_COUNT;
                        end
                        else
                        begin
                            res.read_data = count_shadow;
                        end
                    end
                    OFS_STATUS:  res.read_data = expired_shadow ? EXPIRED_STATUS : 8'h00;
                    default:     ;
                endcase
            end
            OP_WRITE:
            begin
                case (it.reg_offset)
                    OFS_PA_DATA: pa_data_shadow = it.write_data;
                    OFS_PA_DIR:  pa_dir_shadow  = it.write_data;
                    OFS_PB_DATA: pb_data_shadow = it.write_data;
                    OFS_PB_DIR:  pb_dir_shadow  = it.write_data;
                    OFS_START_DIV1, OFS_START_DIV8, OFS_START_DIV64, OFS_START_DIV1024:
                    begin
                        // Offset 4..7 selects prescale 1..4
                        prescale_shadow = it.reg_offset[2:0] - 3'd3;
                        acc_shadow = '0;
                        reload_shadow = it.write_data;
                        count_shadow = it.write_data;
                        expired_shadow = 1'b0;
                    end
                    default:     ;
                endcase
            end
            default: ;
        endcase
        res.timer_expired = expired_shadow;
        if (!was_expired && expired_shadow)
            expirations++;
        return res;
    endfunction

    // Build one random transaction, weighted toward timer traffic
    function automatic in_item_t random_port_timer_item();
        in_item_t it;
        int       pick;
        it.operation   = OP_TICK;
        it.reg_offset  = 4'($urandom_range(0, OFS_WINDOW_TOP));
        it.write_data  = 8'($urandom_range(0, 255));
        it.tick_cycles = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            // Timer start: mostly short counts so expiry comes often
            it.operation  = OP_WRITE;
            it.reg_offset = 4'($urandom_range(OFS_START_DIV1, OFS_START_DIV1024));
            if ($urandom_range(0, 3) != 0)
                it.write_data = 8'($urandom_range(0, 12));
        end
        else if (pick < 42)
        begin
            it.operation = OP_TICK;
            if ($urandom_range(0, 4) == 0)
                it.tick_cycles = 8'($urandom_range(0, 8));
        end
        else if (pick < 62)
        begin
            it.operation = OP_READ;
            case ($urandom_range(0, 2))
                0:       it.reg_offset = OFS_COUNT;
                1:       it.reg_offset = OFS_COUNT_ALT;
                default: it.reg_offset = OFS_STATUS;
            endcase
        end
        else if (pick < 74)
        begin
            it.operation  = OP_WRITE;
            it.reg_offset = 4'($urandom_range(OFS_PA_DATA, OFS_PB_DIR));
        end
        else if (pick < 84)
        begin
            it.operation  = OP_READ;
            it.reg_offset = 4'($urandom_range(OFS_PA_DATA, OFS_PB_DIR));
        end
        else if (pick < 94)
        begin
            // Any offset, decoded or not
            it.operation = 2'($urandom_range(OP_READ, OP_WRITE));
        end
        else
        begin
            it.operation = OP_IGNORED;
        end
        return it;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [3:0] ofs,
                           input logic [7:0] wd, input logic [7:0] cyc,
                           input bit fixed, input logic [7:0] rd, input logic ex);
        stim_row_t row;
        row.item.operation   = op;
        row.item.reg_offset  = ofs;
        row.item.write_data  = wd;
        row.item.tick_cycles = cyc;
        row.fixed            = fixed;
        row.result.read_data     = rd;
        row.result.timer_expired = ex;
        stim_rows.push_back(row);
    endtask

    // Offer one transaction, optionally after an idle burst, and hold it until
    // accepted; then queue what it must produce.
    task automatic offer_item(input in_item_t it, input bit fixed,
                              input out_item_t fixed_result);
        out_item_t predicted;
        if (idle_enabled && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        predicted = predict_port_timer(it);
        expected_results.push_back(fixed ? fixed_result : predicted);
        items_sent++;
        op_count[it.operation]++;
    endtask

    task automatic note_failure(input string what, input out_item_t want,
                                input out_item_t got);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%0t: %s: expected read_data=%02h timer_expired=%0b, %s",
                     $realtime, what, want.read_data, want.timer_expired,
                     $sformatf("got read_data=%02h timer_expired=%0b",
                               got.read_data, got.timer_expired));
    endtask

    // ------------------------------------------------------------------------
    // Sender: directed table first, then random traffic, then the wind-down.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int        n;
        out_item_t none;
        none = '0;

        // Fresh after reset: ports clear, timer stopped at zero
        add_row(OP_READ,  OFS_PA_DATA,       8'hFF, 8'hFF, 1, 8'h00, 1'b0);
        add_row(OP_READ,  OFS_STATUS,        8'h00, 8'h00, 1, 8'h00, 1'b0);
        add_row(OP_TICK,  OFS_PA_DATA,       8'hFF, 8'hFF, 1, 8'h00, 1'b0);
        add_row(OP_READ,  OFS_COUNT,         8'h00, 8'h00, 1, 8'h00, 1'b0);
        // Port registers written with FF, 00, 55 and AA, three read back as stored
        add_row(OP_WRITE, OFS_PA_DATA,       8'hFF, 8'hFF, 1, 8'h00, 1'b0);
        add_row(OP_WRITE, OFS_PA_DIR,        8'h00, 8'h00, 1, 8'h00, 1'b0);
        add_row(OP_WRITE, OFS_PB_DATA,       8'h55, 8'h00, 1, 8'h00, 1'b0);
        add_row(OP_WRITE, OFS_PB_DIR,        8'hAA, 8'h00, 1, 8'h00, 1'b0);
        add_row(OP_READ,  OFS_PA_DATA,       8'h00, 8'h00, 1, 8'hFF, 1'b0);
        add_row(OP_READ,  OFS_PB_DATA,       8'h00, 8'h00, 1, 8'h55, 1'b0);
        add_row(OP_READ,  OFS_PB_DIR,        8'h00, 8'h00, 1, 8'hAA, 1'b0);
        // Divide-by-one timer runs down exactly to zero
        add_row(OP_WRITE, OFS_START_DIV1,    8'h03, 8'h00, 1, 8'h00, 1'b0);
        add_row(OP_TICK,  OFS_PA_DATA,       8'h00, 8'h02, 0, 8'h00, 1'b0);
        add_row(OP_READ,  OFS_COUNT_ALT,     8'h00, 8'h00, 0, 8'h00, 1'b0);
        add_row(OP_TICK,  OFS_PA_DATA,       8'h00, 8'h01, 1, 8'h00, 1'b1);
        // Expired timer ignores ticks; status shows it, a count read restarts
        add_row(OP_TICK,  OFS_PA_DATA,       8'h00, 8'hC8, 1, 8'h00, 1'b1);
        add_row(OP_READ,  OFS_STATUS,        8'h00, 8'h00, 1, 8'h80, 1'b1);
        add_row(OP_READ,  OFS_COUNT,         8'h00, 8'h00, 1, 8'h00, 1'b0);
        add_row(OP_READ,  OFS_COUNT,         8'h00, 8'h00, 1, 8'hFF, 1'b0);
        // Divide-by-64 needs a whole period before the count moves
        add_row(OP_WRITE, OFS_START_DIV64,   8'h01, 8'h00, 1, 8'h00, 1'b0);
        add_row(OP_TICK,  OFS_PA_DATA,       8'h00, 8'h3F, 0, 8'h00, 1'b0);
        add_row(OP_TICK,  OFS_PA_DATA,       8'h00, 8'h01, 1, 8'h00, 1'b1);
        // Restart at divide-by-8 and divide-by-1024 clears expiry
        add_row(OP_WRITE, OFS_START_DIV8,    8'hFF, 8'h00, 1, 8'h00, 1'b0);
        add_row(OP_TICK,  OFS_PA_DATA,       8'h00, 8'hFF, 0, 8'h00, 1'b0);
        add_row(OP_WRITE, OFS_START_DIV1024, 8'h10, 8'h00, 1, 8'h00, 1'b0);
        // Undecoded offsets and the ignored operation
        add_row(OP_READ,  OFS_START_DIV8,    8'hFF, 8'hFF, 1, 8'h00, 1'b0);
        add_row(OP_READ,  OFS_WINDOW_TOP,    8'hFF, 8'hFF, 1, 8'h00, 1'b0);
        add_row(OP_WRITE, OFS_UNMAPPED_LO,   8'hFF, 8'hFF, 1, 8'h00, 1'b0);
        add_row(OP_IGNORED, OFS_COUNT,       8'hFF, 8'hFF, 1, 8'h00, 1'b0);

        @(posedge clk);
        while (!rst_n) @(posedge clk);

        foreach (stim_rows[i])
            offer_item(stim_rows[i].item, stim_rows[i].fixed, stim_rows[i].result);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Once mid-run, drop valid and let every pending result drain
            if (n == DRAIN_PAUSE_AT)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (expected_results.size() != 0);
            end
            // Run the tail at full rate on both sides
            if (n == RANDOM_ITEMS - QUIET_TAIL)
                idle_enabled = 1'b0;
            offer_item(random_port_timer_item(), 1'b0, none);
        end

        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d transactions: %0d ticks, %0d reads, %0d writes, %0d ignored.",
                 items_sent, op_count[OP_TICK], op_count[OP_READ],
                 op_count[OP_WRITE], op_count[OP_IGNORED]);
        $display("Timer expired %0d times; input stalled on %0d cycles; %0d mismatches.",
                 expirations, backpressure_cycles, failures);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: check each accepted result against the oldest expectation and
    // drive out_ready with random stall bursts plus one long hold-off that
    // fills the block and pushes back on the input.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int        stall_left;
        bit        long_hold_done;
        out_item_t want;
        stall_left = 0;
        long_hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    note_failure("result with nothing pending", '0, out_data);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.read_data !== want.read_data
                        || out_data.timer_expired !== want.timer_expired)
                        note_failure("result mismatch", want, out_data);
                end
            end

            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!long_hold_done && items_sent >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (idle_enabled && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 17);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (in_valid && !in_ready)
            backpressure_cycles <= backpressure_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d results pending.",
                     quiet_cycles, expected_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
